// File: design/ahp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AU header parser package
// Shared result codes, control/status bundles and fixed constants.
// ----------------------------------------------------------------------------
package ahp_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_UNIT      = 2'd0,
        ST_FRAGMENT  = 2'd1,
        ST_MALFORMED = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic take;     // request accepted this cycle
        logic decide;   // evaluate packet, load first result
        logic emit;     // load next unit descriptor
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic multi;      // packet is good and carries more than one unit
        logic last_unit;  // unit being emitted is the final one
    } t_stat;

    localparam int          RESULT_CAP   = 16;       // most results per packet
    localparam logic [16:0] SUM_CAP      = 17'h1FFFF;
    localparam logic [16:0] MIN_PACKET   = 17'd4;
    localparam logic [16:0] HDR_PREFIX   = 17'd2;    // AU-headers-length field
    localparam logic [4:0]  MAX_UNITS_RST = 5'd16;

endpackage

// File: design/ahp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AU header parser controller
// Sequences byte intake, the end-of-packet verdict and descriptor emission.
// ----------------------------------------------------------------------------
module ahp_ctrl
    import ahp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_last_byte,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    assign o_cmd.take   = i_start && !r_busy;
    assign o_cmd.decide = (r_state == S_DECIDE);
    assign o_cmd.emit   = (r_state == S_EMIT);
    assign o_busy       = r_busy;

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && !r_busy && i_last_byte) begin
                    n_state = S_DECIDE;
                    n_busy  = 1'b1;
                end
            end
            S_DECIDE: begin
                if (i_stat.multi) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                    n_busy  = 1'b0;
                end
            end
            S_EMIT: begin
                if (i_stat.last_unit) begin
                    n_state = S_IDLE;
                    n_busy  = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

`ifndef ASSERT_OFF
    a_busy_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy == (r_state != S_IDLE)))
        else $error("busy out of step with state");
    a_decide_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |=> (r_state != S_DECIDE))
        else $error("decide state held");
    a_emit_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_EMIT) |-> $past(r_state == S_DECIDE))
        else $error("emit entered without decide");
`endif

endmodule

// File: design/ahp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AU header parser datapath
// Byte counting, header field capture, unit size store and result registers.
// ----------------------------------------------------------------------------
module ahp_datapath
    import ahp_pkg::*;
#(
    parameter int MAX_UNITS        = 16,
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    output t_stat       o_stat,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [3:0]  o_unit_index,
    output logic [15:0] o_unit_offset,
    output logic [15:0] o_unit_length,
    output logic [12:0] o_fragment_total,
    output logic        o_last_result
);

    localparam int          STORE_DEPTH = (MAX_UNITS < RESULT_CAP) ? MAX_UNITS : RESULT_CAP;
    localparam int          IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [4:0]  LIMIT_CAP   = 5'(STORE_DEPTH);
    localparam logic [16:0] BYTES_MAX   = 17'(MAX_PACKET_BYTES);
    localparam logic [16:0] BYTES_SAT   = 17'(MAX_PACKET_BYTES + 1);
    localparam logic [16:0] UNITS_MAX   = 17'(MAX_UNITS);
    localparam logic [16:0] STORE_MAX   = 17'(STORE_DEPTH);

    // configuration
    logic [4:0]  r_max_units, n_max_units;

    // packet state
    logic [16:0] r_byte_count, n_byte_count;
    logic [15:0] r_hlen, n_hlen;
    logic [16:0] r_hdr, n_hdr;
    logic [7:0]  r_hold, n_hold;
    logic [16:0] r_sum, n_sum;
    logic        r_malformed, n_malformed;
    logic [4:0]  r_idx, n_idx;
    logic [16:0] r_off, n_off;

    logic [12:0] r_unit_sizes [STORE_DEPTH];

    // result registers
    logic        r_valid, n_valid;
    t_status     r_status, n_status;
    logic [3:0]  r_res_idx, n_res_idx;
    logic [15:0] r_res_off, n_res_off;
    logic [15:0] r_res_len, n_res_len;
    logic [12:0] r_res_frag, n_res_frag;
    logic        r_res_last, n_res_last;

    // store write port
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [12:0]      wr_data;

    logic [4:0]  limit;
    logic [15:0] hl_new;
    logic [15:0] au_hdr;
    logic [16:0] unit_pos;
    logic [17:0] sum_ext;
    logic [11:0] nunits;
    logic [16:0] body_len;
    logic        bad, over, under, good;
    logic [12:0] size_rd;

    assign limit    = (r_max_units > LIMIT_CAP) ? LIMIT_CAP : r_max_units;
    assign hl_new   = {r_hold, i_payload_byte};
    assign au_hdr   = {r_hold, i_payload_byte};
    assign unit_pos = (r_byte_count - HDR_PREFIX) >> 1;
    assign sum_ext  = {1'b0, r_sum} + {5'd0, au_hdr[15:3]};
    assign nunits   = r_hlen[15:4];
    assign body_len = r_byte_count - r_hdr;
    assign size_rd  = r_unit_sizes[r_idx[IDX_W-1:0]];

    // end-of-packet verdict, all from registered state
    assign bad   = r_malformed || (r_byte_count < MIN_PACKET) || (r_hdr >= r_byte_count)
                || (nunits == 12'd0) || (nunits > {7'd0, limit});
    assign over  = r_sum > body_len;
    assign under = r_sum < body_len;
    assign good  = !bad && !over && !under;

    assign o_stat.multi     = good && (nunits != 12'd1);
    assign o_stat.last_unit = ({7'd0, r_idx} + 12'd1) == nunits;

    always_comb begin
        n_max_units  = r_max_units;
        n_byte_count = r_byte_count;
        n_hlen       = r_hlen;
        n_hdr        = r_hdr;
        n_hold       = r_hold;
        n_sum        = r_sum;
        n_malformed  = r_malformed;
        n_idx        = r_idx;
        n_off        = r_off;
        n_valid      = 1'b0;
        n_status     = r_status;
        n_res_idx    = r_res_idx;
        n_res_off    = r_res_off;
        n_res_len    = r_res_len;
        n_res_frag   = r_res_frag;
        n_res_last   = r_res_last;
        wr_en        = 1'b0;
        wr_idx       = unit_pos[IDX_W-1:0];
        wr_data      = au_hdr[15:3];

        if (i_cfg_we) begin
            n_max_units = i_cfg_data;
        end

        if (i_cmd.take) begin
            if (r_byte_count < BYTES_MAX) begin
                n_byte_count = r_byte_count + 17'd1;
                if (r_byte_count == 17'd0) begin
                    n_hold = i_payload_byte;
                end else if (r_byte_count == 17'd1) begin
                    n_hlen = hl_new;
                    n_hdr  = HDR_PREFIX + {4'd0, hl_new[15:3]};
                    if ((hl_new == 16'd0) || (hl_new[3:0] != 4'd0)
                        || (hl_new[15:4] > {7'd0, limit})) begin
                        n_malformed = 1'b1;
                    end
                end else if (!r_malformed && (r_byte_count < r_hdr)) begin
                    if (!r_byte_count[0]) begin
                        n_hold = i_payload_byte;
                    end else if ((au_hdr[2:0] != 3'd0) || (au_hdr[15:3] == 13'd0)
                                 || (unit_pos >= UNITS_MAX)) begin
                        n_malformed = 1'b1;
                    end else begin
                        wr_en = (unit_pos < STORE_MAX);
                        n_sum = sum_ext[17] ? SUM_CAP : sum_ext[16:0];
                    end
                end
            end else begin
                n_malformed  = 1'b1;
                n_byte_count = BYTES_SAT;
            end
        end

        if (i_cmd.decide) begin
            n_valid    = 1'b1;
            n_res_idx  = 4'd0;
            n_res_frag = 13'd0;
            n_res_last = 1'b1;
            if (bad || under || (over && (nunits != 12'd1))) begin
                n_status  = ST_MALFORMED;
                n_res_off = 16'd0;
                n_res_len = 16'd0;
            end else if (over) begin
                // lone unit cut short: report what is present
                n_status   = ST_FRAGMENT;
                n_res_off  = r_hdr[15:0];
                n_res_len  = body_len[15:0];
                n_res_frag = size_rd;
            end else begin
                n_status   = ST_UNIT;
                n_res_off  = r_hdr[15:0];
                n_res_len  = {3'd0, size_rd};
                n_res_last = (nunits == 12'd1);
                n_off      = r_hdr + {4'd0, size_rd};
                n_idx      = 5'd1;
            end
        end else if (i_cmd.emit) begin
            n_valid    = 1'b1;
            n_status   = ST_UNIT;
            n_res_idx  = r_idx[3:0];
            n_res_off  = r_off[15:0];
            n_res_len  = {3'd0, size_rd};
            n_res_frag = 13'd0;
            n_res_last = o_stat.last_unit;
            n_off      = r_off + {4'd0, size_rd};
            n_idx      = r_idx + 5'd1;
        end

        // packet done: back to empty
        if (n_valid && n_res_last) begin
            n_byte_count = 17'd0;
            n_hlen       = 16'd0;
            n_hdr        = HDR_PREFIX;
            n_hold       = 8'd0;
            n_sum        = 17'd0;
            n_malformed  = 1'b0;
            n_idx        = 5'd0;
            n_off        = 17'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_units  <= MAX_UNITS_RST;
            r_byte_count <= 17'd0;
            r_hlen       <= 16'd0;
            r_hdr        <= HDR_PREFIX;
            r_hold       <= 8'd0;
            r_sum        <= 17'd0;
            r_malformed  <= 1'b0;
            r_idx        <= 5'd0;
            r_off        <= 17'd0;
            r_valid      <= 1'b0;
        end else begin
            r_max_units  <= n_max_units;
            r_byte_count <= n_byte_count;
            r_hlen       <= n_hlen;
            r_hdr        <= n_hdr;
            r_hold       <= n_hold;
            r_sum        <= n_sum;
            r_malformed  <= n_malformed;
            r_idx        <= n_idx;
            r_off        <= n_off;
            r_valid      <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_res_idx  <= n_res_idx;
        r_res_off  <= n_res_off;
        r_res_len  <= n_res_len;
        r_res_frag <= n_res_frag;
        r_res_last <= n_res_last;
        if (wr_en) begin
            r_unit_sizes[wr_idx] <= wr_data;
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_unit_index     = r_res_idx;
    assign o_unit_offset    = r_res_off;
    assign o_unit_length    = r_res_len;
    assign o_fragment_total = r_res_frag;
    assign o_last_result    = r_res_last;

`ifndef ASSERT_OFF
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_count <= BYTES_SAT))
        else $error("byte count past saturation");
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res_last) |-> (r_idx == 5'd0 && !r_malformed))
        else $error("packet state not cleared after final result");
    a_no_take_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.take && (i_cmd.decide || i_cmd.emit)))
        else $error("byte taken during result emission");
`endif

endmodule

// File: design/aac_hbr_au_header_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AAC-hbr AU header parser core
// Parses the AU-header section of an RTP payload byte by byte and reports one
// descriptor per access unit, a lone fragment, or a malformed packet.
// ----------------------------------------------------------------------------
// A non-final byte is taken with busy low. After the final byte is taken,
//   the decision state registers the first result, then the emit state one
//   per cycle; busy stays high until the final result is registered.
// Throughput: one byte per cycle within a packet, none while results emit;
//   the one-cycle result strobe cannot be stalled by the receiver.
// Reset: synchronous, active low; clears packet state and sets max_units to 16.
// ----------------------------------------------------------------------------
module aac_hbr_au_header_parser_core
    import ahp_pkg::*;
#(
    parameter int MAX_UNITS        = 16,
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte request
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_last_byte,
    // configuration
    input  logic        i_max_units_we,
    input  logic [4:0]  i_max_units,
    // results
    output logic        o_result_valid,
    output logic [1:0]  o_status,
    output logic [3:0]  o_unit_index,
    output logic [15:0] o_unit_offset,
    output logic [15:0] o_unit_length,
    output logic [12:0] o_fragment_total,
    output logic        o_last_result
);

    t_cmd  cmd;
    t_stat stat;

    // Controller: idle accepts a request each cycle; the final byte moves it
    // to a one-cycle decision, then an emit loop for multi-unit packets.
    ahp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_last_byte (i_last_byte),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    // Datapath: header length and AU header checks per byte, unit size store,
    // registered result outputs.
    ahp_datapath #(
        .MAX_UNITS        (MAX_UNITS),
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_payload_byte   (i_payload_byte),
        .i_cfg_we         (i_max_units_we),
        .i_cfg_data       (i_max_units),
        .o_stat           (stat),
        .o_valid          (o_result_valid),
        .o_status         (o_status),
        .o_unit_index     (o_unit_index),
        .o_unit_offset    (o_unit_offset),
        .o_unit_length    (o_unit_length),
        .o_fragment_total (o_fragment_total),
        .o_last_result    (o_last_result)
    );

`ifndef ASSERT_OFF
    // final result shown while the block is already free for the next packet
    a_last_frees_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last_result) |-> !busy)
        else $error("busy high on final result");
    // a final byte always leads to a decision cycle
    a_last_byte_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_byte) |=> busy)
        else $error("final byte did not start result phase");
    // malformed and fragment results stand alone
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == ST_MALFORMED || o_status == ST_FRAGMENT))
        |-> (o_last_result && o_unit_index == 4'd0))
        else $error("malformed or fragment result not alone");
`endif

endmodule
